/* rtl/ddrle_pkg.sv */
// Package for the decimal digit run-length encoder: payload structs, FSM state,
// internal control structs and fixed field widths. No dependencies.
package ddrle_pkg;

   localparam int VALUE_BITS = 31;
   localparam int DIGIT_BITS = 4;
   localparam int NUM_DIGITS = 10;
   localparam int BCD_BITS   = NUM_DIGITS * DIGIT_BITS;
   localparam int RUN_BITS   = 16;
   localparam int BIT_CNT_W  = 5;
   localparam int DIG_CNT_W  = 4;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  end_of_sequence;
   } req_type;

   typedef struct packed {
      logic [DIGIT_BITS-1:0] digit;
      logic [RUN_BITS-1:0]   run_length;
      logic                  final_run;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // controls for the binary to BCD shifter
   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } conv_ctl_type;

   // controls for the run encoder
   typedef struct packed {
      logic                  digit_valid;
      logic                  flush;
      logic [DIGIT_BITS-1:0] digit;
   } enc_ctl_type;

endpackage

/* rtl/decimal_digit_run_length_encoder.sv */
// Top level of the decimal digit run-length encoder: sequencer FSM around the
// BCD converter and run encoder. Uses ddrle_pkg, ddrle_bcd_conv, ddrle_run_enc.
//
//   channel | ports                            | direction | carries
//   --------+----------------------------------+-----------+--------------------------
//   request | req_valid, req_stall, req_data   | in        | value, end_of_sequence
//   result  | rsp_valid, rsp_stall, rsp_data   | out       | digit, run_length, final_run
//
// Sequence: a request is taken in ST_IDLE, then its 31 value bits are converted
//   in ST_CONV (one value bit a cycle through the shift-add-3 BCD register), its
//   10 BCD digits are scanned in ST_SCAN, and ST_FLUSH follows when end_of_sequence
//   is set; only then is the next request taken, in ST_IDLE.
// req_stall is high from acceptance until the request is fully processed.
// A stalled result holds the digit scan and the flush.
// Reset (synchronous) discards any open run and drops a pending result.
module decimal_digit_run_length_encoder #(
   parameter int COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ddrle_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ddrle_pkg::rsp_type rsp_data
);
   import ddrle_pkg::*;

   state_type              state_ff, state_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   started_ff, started_in;   // leading zeros skipped
   logic                   eos_ff, eos_in;
   logic                   req_accept;
   logic                   enc_ready;
   logic                   last_bit, last_digit, emit_digit;
   logic [DIGIT_BITS-1:0]  top_digit;
   conv_ctl_type           conv_ctl;
   enc_ctl_type            enc_ctl;

   assign req_accept = req_valid && !req_stall;
   assign last_bit   = (bit_cnt_ff == BIT_CNT_W'(VALUE_BITS - 1));
   assign last_digit = (dig_cnt_ff == DIG_CNT_W'(NUM_DIGITS - 1));
   // a value of zero still gives its final digit 0
   assign emit_digit = started_ff || (top_digit != '0) || last_digit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = ST_CONV;
         end
         ST_CONV: begin
            if (last_bit) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (enc_ready && last_digit) state_in = eos_ff ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            if (enc_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and counters; req_stall is low in idle, so valid alone accepts
   always_comb begin
      req_stall           = 1'b1;
      conv_ctl            = '0;
      enc_ctl             = '0;
      enc_ctl.digit       = top_digit;
      bit_cnt_in          = bit_cnt_ff;
      dig_cnt_in          = dig_cnt_ff;
      started_in          = started_ff;
      eos_in              = eos_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            conv_ctl.load = req_valid;
            bit_cnt_in    = '0;
            dig_cnt_in    = '0;
            started_in    = 1'b0;
            if (req_valid) eos_in = req_data.end_of_sequence;
         end
         ST_CONV: begin
            conv_ctl.step = 1'b1;
            bit_cnt_in    = bit_cnt_ff + BIT_CNT_W'(1);
         end
         ST_SCAN: begin
            if (enc_ready) begin
               conv_ctl.shift      = 1'b1;
               enc_ctl.digit_valid = emit_digit;
               started_in          = emit_digit;
               dig_cnt_in          = dig_cnt_ff + DIG_CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            enc_ctl.flush = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         started_ff <= 1'b0;
         eos_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         started_ff <= started_in;
         eos_ff     <= eos_in;
      end
   end

   ddrle_bcd_conv u_conv (
      .clock     (clock),
      .ctl       (conv_ctl),
      .value     (req_data.value),
      .top_digit (top_digit)
   );

   ddrle_run_enc #(
      .COUNT_BITS (COUNT_BITS)
   ) u_enc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (enc_ctl),
      .enc_ready (enc_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/ddrle_bcd_conv.sv */
// Bit-serial binary to BCD converter (shift and add 3), then a digit-serial
// shift out of the BCD word, most significant digit first. Uses ddrle_pkg.
module ddrle_bcd_conv (
   input  logic                                  clock,
   input  ddrle_pkg::conv_ctl_type               ctl,
   input  logic [ddrle_pkg::VALUE_BITS-1:0]      value,
   output logic [ddrle_pkg::DIGIT_BITS-1:0]      top_digit
);
   import ddrle_pkg::*;

   logic [BCD_BITS-1:0]   bcd_ff, bcd_in, adj;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS]
                                              + DIGIT_BITS'(3);
         end else begin
            adj[i*DIGIT_BITS +: DIGIT_BITS] = bcd_ff[i*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      priority if (ctl.load) begin
         bcd_in = '0;
         bin_in = value;
      end else if (ctl.step) begin
         bcd_in = {adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
      end else if (ctl.shift) begin
         bcd_in = {bcd_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: DIGIT_BITS];

endmodule

/* rtl/ddrle_run_enc.sv */
// Run encoder: open run state, saturating run counter and the response
// output register. Uses ddrle_pkg.
module ddrle_run_enc #(
   parameter int COUNT_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ddrle_pkg::enc_ctl_type ctl,
   output logic                   enc_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ddrle_pkg::rsp_type     rsp_data
);
   import ddrle_pkg::*;

   localparam int CntW   = (COUNT_BITS < RUN_BITS) ? COUNT_BITS : RUN_BITS;
   localparam int CntLim = (COUNT_BITS < RUN_BITS) ? (2**COUNT_BITS - 1)
                                                   : (2**RUN_BITS - 1);

   logic                  valid_ff, valid_in;
   rsp_type               data_ff, data_in;
   logic                  open_ff, open_in;
   logic [DIGIT_BITS-1:0] digit_ff, digit_in;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  out_free;

   // output register can take a new result this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      open_in  = open_ff;
      digit_in = digit_ff;
      count_in = count_ff;
      if (out_free) begin
         valid_in = 1'b0;
         priority if (ctl.flush) begin
            valid_in           = open_ff;
            data_in.digit      = digit_ff;
            data_in.run_length = RUN_BITS'(count_ff);
            data_in.final_run  = 1'b1;
            open_in            = 1'b0;
            digit_in           = '0;
            count_in           = '0;
         end else if (ctl.digit_valid) begin
            if (open_ff && ctl.digit == digit_ff) begin
               if (count_ff != CntW'(CntLim)) begin
                  count_in = count_ff + CntW'(1);
               end
            end else begin
               valid_in           = open_ff;
               data_in.digit      = digit_ff;
               data_in.run_length = RUN_BITS'(count_ff);
               data_in.final_run  = 1'b0;
               open_in            = 1'b1;
               digit_in           = ctl.digit;
               count_in           = CntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         open_ff  <= 1'b0;
         digit_ff <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         open_ff  <= open_in;
         digit_ff <= digit_in;
         count_ff <= count_in;
      end
      data_ff <= data_in;
   end

   assign enc_ready = out_free;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/ddrle_checker.sv */
// Port-level checker for the decimal digit run-length encoder, with its bind.
// Uses ddrle_pkg; attaches to decimal_digit_run_length_encoder.
module ddrle_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input ddrle_pkg::req_type req_data,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input ddrle_pkg::rsp_type rsp_data
);
   import ddrle_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.digit <= DIGIT_BITS'(9))
      else $error("result digit above 9");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.run_length != '0)
      else $error("zero run length");

   // an accepted request keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in progress");

endmodule

bind decimal_digit_run_length_encoder ddrle_checker u_ddrle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for decimal_digit_run_length_encoder: a run scoreboard
// class predicts the (digit, run length) pairs, plain tasks drive the request side.
// Depends on ddrle_pkg and the encoder RTL only.

class rle_scoreboard;
   longint unsigned     run_limit;
   logic [3:0]          open_digit;
   longint unsigned     open_count;
   bit                  run_open;
   ddrle_pkg::rsp_type  expected_runs[$];
   int                  errors;
   int                  requests_seen;
   int                  runs_checked;
   int                  final_runs;
   int                  saturated_runs;

   function new(longint unsigned limit);
      run_limit      = limit;
      open_digit     = '0;
      open_count     = 0;
      run_open       = 0;
      errors         = 0;
      requests_seen  = 0;
      runs_checked   = 0;
      final_runs     = 0;
      saturated_runs = 0;
   endfunction

   function int pending();
      return expected_runs.size();
   endfunction

   function void close_run(bit last);
      ddrle_pkg::rsp_type r;
      r.digit      = open_digit;
      r.run_length = open_count[15:0];
      r.final_run  = last;
      if (open_count == run_limit) saturated_runs++;
      if (last) final_runs++;
      expected_runs.push_back(r);
   endfunction

   // split the value into decimal digits, MSD first, and extend the open run
   function void note_request(ddrle_pkg::req_type req);
      logic [30:0] v;
      logic [3:0]  digs[10];
      int          nd;
      v  = req.value;
      nd = 0;
      requests_seen++;
      if (v == 0) begin
         digs[0] = 4'd0;
         nd      = 1;
      end else begin
         while (v != 0 && nd < 10) begin
            digs[nd] = 4'(v % 10);
            v        = v / 10;
            nd++;
         end
      end
      for (int i = nd - 1; i >= 0; i--) begin
         if (run_open && digs[i] == open_digit) begin
            if (open_count < run_limit) open_count++;
         end else begin
            if (run_open) close_run(1'b0);
            open_digit = digs[i];
            open_count = 1;
            run_open   = 1;
         end
      end
      if (req.end_of_sequence) begin
         if (run_open) close_run(1'b1);
         open_digit = '0;
         open_count = 0;
         run_open   = 0;
      end
   endfunction

   function void check_run(ddrle_pkg::rsp_type act);
      ddrle_pkg::rsp_type exp_run;
      runs_checked++;
      if (expected_runs.size() == 0) begin
         $error("unexpected run: digit %0d, run_length %0d, final_run %0d",
                act.digit, act.run_length, act.final_run);
         errors++;
         return;
      end
      exp_run = expected_runs.pop_front();
      if (act.digit !== exp_run.digit) begin
         $error("digit: expected %0d, actual %0d", exp_run.digit, act.digit);
         errors++;
      end
      if (act.run_length !== exp_run.run_length) begin
         $error("run_length: expected %0d, actual %0d",
                exp_run.run_length, act.run_length);
         errors++;
      end
      if (act.final_run !== exp_run.final_run) begin
         $error("final_run: expected %0d, actual %0d",
                exp_run.final_run, act.final_run);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int              COUNT_BITS     = 16;
   localparam longint unsigned CEIL_RAW       = (64'd1 << COUNT_BITS) - 64'd1;
   localparam longint unsigned RUN_LIMIT      = (CEIL_RAW > 64'd65535) ? 64'd65535 : CEIL_RAW;
   localparam int              ITEMS_PER_PHASE = 36;
   // time for a request that produced no run to finish; leave generous margin
   localparam int              SETTLE_CYCLES  = 80;
   localparam int              END_CYCLES     = 200;
   localparam int              WATCHDOG_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   ddrle_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   ddrle_pkg::rsp_type rsp_data;

   // idle percentages for the current phase
   int gap_pct   = 0;
   int stall_pct = 0;
   int idle_cycles = 0;

   rle_scoreboard runs_sb = new(RUN_LIMIT);

   decimal_digit_run_length_encoder #(
      .COUNT_BITS(COUNT_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: both handshakes sampled at the edge, plus a no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) runs_sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) runs_sb.check_run(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d runs outstanding",
                     WATCHDOG_LIMIT, runs_sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // present one request, with a random lead-in gap; valid stays high after
   // acceptance so back-to-back requests never drop it
   task automatic send_request(input logic [30:0] value, input logic eos);
      ddrle_pkg::req_type req;
      int                 gap;
      gap = 0;
      while ($urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.value           = value;
      req.end_of_sequence = eos;
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off the sender until every predicted run is back, then let the
   // encoder finish any request that produced no run
   task automatic drain_runs();
      req_valid <= 1'b0;
      while (runs_sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mix of full-width noise, small values, zeros and digit-repetitive
   // values so runs often span request boundaries
   function automatic logic [30:0] random_value();
      int              kind;
      int              n;
      int              a;
      int              b;
      longint unsigned acc;
      kind = $urandom_range(9);
      acc  = 0;
      a    = $urandom_range(9);
      b    = $urandom_range(9);
      n    = $urandom_range(1, 9);
      case (kind)
         0, 1: acc = $urandom;
         2: acc = $urandom_range(99);
         3: acc = 0;
         4, 5, 6: repeat (n) acc = acc * 10 + a;
         default: repeat (n) acc = acc * 10 + ($urandom_range(1) ? a : b);
      endcase
      return acc[30:0];
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, zero, boundary-spanning runs, max runs per request
      send_request(31'd0, 1'b1);
      send_request(31'd2147483647, 1'b1);
      send_request(31'd1111111111, 1'b0);
      send_request(31'd1111111111, 1'b1);
      send_request(31'd0, 1'b0);
      send_request(31'd0, 1'b0);
      send_request(31'd0, 1'b1);
      send_request(31'd1234567890, 1'b0);
      send_request(31'd987654321, 1'b0);
      send_request(31'd1023456789, 1'b1);
      send_request(31'd5, 1'b0);
      send_request(31'd55, 1'b1);
      send_request(31'd1000000000, 1'b1);
      send_request(31'd7, 1'b0);
      send_request(31'd8, 1'b0);
      send_request(31'd8, 1'b1);
      send_request(31'h4000_0000, 1'b0);
      send_request(31'h5555_5555, 1'b0);
      send_request(31'h2AAA_AAAA, 1'b1);
      send_request(31'd9, 1'b1);
      send_request(31'd1, 1'b0);
      send_request(31'd11, 1'b0);
      send_request(31'd12, 1'b1);
      drain_runs();

      // random traffic under the four idling patterns
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 85; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 85; end
            default: begin gap_pct = 12; stall_pct = 12; end
         endcase
         repeat (ITEMS_PER_PHASE) send_request(random_value(), ($urandom_range(5) == 0));
         drain_runs();
      end

      // close whatever run is still open
      send_request(random_value(), 1'b1);
      req_valid <= 1'b0;
      while (runs_sb.pending() != 0) @(posedge clock);
      repeat (END_CYCLES) @(posedge clock);

      if (runs_sb.pending() != 0) begin
         $error("%0d predicted runs never arrived", runs_sb.pending());
         runs_sb.errors++;
      end
      $display("Encoded %0d requests into %0d checked runs (%0d sequence flushes, %0d at the",
               runs_sb.requests_seen, runs_sb.runs_checked, runs_sb.final_runs,
               runs_sb.saturated_runs);
      $display("count ceiling), over directed values and four idle/stall patterns.");
      if (runs_sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
